FILE: design/knn_idw_table_interpolator_macros.svh
// Assertion macros used by the interpolator datapath (knn_dp).
`ifndef KNN_IDW_TABLE_INTERPOLATOR_MACROS_SVH
`define KNN_IDW_TABLE_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KNN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KNN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KNN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KNN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/knn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg
// Types, widths and codes shared by the table interpolator modules.
// ----------------------------------------------------------------------------
package knn_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_NB_DEF      = 8;
    localparam int ANG_W      = 17;
    localparam int COEF_W     = 32;
    localparam int NCOEF      = 6;
    localparam int ROW_W      = 2 * ANG_W + NCOEF * COEF_W;
    localparam int S_TDATA_W  = ((ROW_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = NCOEF * COEF_W;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 3;
    localparam int SCALE_W    = 16;
    localparam int NU_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W      = ANG_W + 1;
    localparam int DIST_W     = MAG_W + SCALE_W - 8;
    localparam int D2_W       = 2 * DIST_W + 1;
    localparam int DIV_W      = 64;
    localparam int W_W        = 17;
    localparam int ACC_W      = 64;
    localparam int SHIFT_W    = 4;
    localparam int NB_IDX_W   = 5;
    localparam int NB_CNT_W   = 6;
    localparam int CO_IDX_W   = 3;
    localparam int NUM_LIMIT_BIT = 47;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STS_BLEND   = 3'd0,
        STS_EXACT   = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_LOADED  = 3'd3,
        STS_FULL    = 3'd4,
        STS_CLEARED = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_SCALE = 2'd0,
        CFG_BETA_SCALE  = 2'd1,
        CFG_NEIGHBORS   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ROW,
        SRC_RES
    } t_src;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_HIT_RD,
        ST_PREP,
        ST_W_START,
        ST_W_WAIT,
        ST_W_LATCH,
        ST_MUL,
        ST_FLUSH,
        ST_B_START,
        ST_B_WAIT,
        ST_B_STORE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                capture;
        logic                clear;
        logic                load_wr;
        logic                scan_start;
        logic                hit_read;
        logic                prep;
        logic                wdiv_start;
        logic                w_latch;
        logic                mul;
        logic                bdiv_start;
        logic                b_store;
        logic                emit;
        logic [NB_IDX_W-1:0] nb;
        logic [CO_IDX_W-1:0] co;
        t_status             status;
        t_src                src;
    } t_cmd;

    typedef struct packed {
        t_kind               kind;
        logic                empty;
        logic                full;
        logic                scan_busy;
        logic                hit;
        logic [NB_CNT_W-1:0] nsel;
        logic                div_done;
        logic                out_free;
    } t_sts;
endpackage

FILE: design/knn_idw_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_idw_table_interpolator
// Table of sample points blended by inverse squared distance of the k
// nearest points. A query scans the table through the single memory read
// port and the distance pipeline, then runs one weight division per blended
// neighbor and six final divisions, all on one 64-bit divider that produces
// one quotient bit per cycle. An exact hit finishes right after the scan.
// The result register lets the next request be accepted while a result
// waits.
// ----------------------------------------------------------------------------
module knn_idw_table_interpolator
    import knn_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int MAX_NEIGHBORS = MAX_NB_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // alpha, beta, point_force_x/y/z, point_moment_x/y/z, zero fill
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // force_x/y/z, moment_x/y/z
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [STAT_W-1:0]     m_axis_tuser
);
    t_cmd cmd;
    t_sts sts;

    knn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    knn_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .i_in_kind  (s_axis_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );
endmodule

FILE: design/knn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module knn_div
    import knn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem, r_quot, r_dvs;
    logic [DIV_W:0]   sh, diff;
    logic             ge;

    always_comb begin
        sh   = {r_rem, r_quot[DIV_W-1]};
        diff = sh - {1'b0, r_dvs};
        ge   = (sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            r_quot <= {r_quot[DIV_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: design/knn_dp.sv
`timescale 1ns / 1ps
`include "knn_idw_table_interpolator_macros.svh"
// ----------------------------------------------------------------------------
// knn_dp
// Point table, distance pipeline, nearest list, divider, accumulators and
// the result register.
// ----------------------------------------------------------------------------
module knn_dp
    import knn_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int MAX_NEIGHBORS = MAX_NB_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  i_in_data,
    input  logic [KIND_W-1:0]     i_in_kind,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic [STAT_W-1:0]     o_m_tuser
);
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int KIW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    logic [SCALE_W-1:0] r_inv_a, r_inv_b;
    logic [NU_W-1:0]    r_nu;
    logic [ROW_W-1:0]   r_in_row;
    t_kind              r_kind;
    logic [CW-1:0]      r_count;

    logic [ROW_W-1:0] mem [TABLE_DEPTH];
    logic [ROW_W-1:0] r_rd_row;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    logic          r_scan_on;
    logic [CW-1:0] r_scan_addr;
    logic          r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0] r_i1, r_i2, r_i3, r_i4;
    logic [DIST_W-1:0] r_da, r_db;
    logic [2*DIST_W-1:0] r_da2, r_db2;
    logic [D2_W-1:0] r_d2;

    logic [D2_W-1:0]     r_bd [MAX_NEIGHBORS];
    logic [AW-1:0]       r_bi [MAX_NEIGHBORS];
    logic [NB_CNT_W-1:0] r_nsel, r_k, k_c, pos;
    logic                skip;
    logic                r_hit;
    logic [AW-1:0]       r_hit_idx;

    logic [SHIFT_W-1:0] r_shift, sh_c;
    logic [DIV_W-1:0]   r_num, r_wsum;
    logic [W_W-1:0]     r_w;
    logic signed [ACC_W-1:0] r_acc [NCOEF];
    logic signed [W_W+COEF_W:0] r_prod;
    logic [CO_IDX_W-1:0] r_pidx;
    logic                r_pvld;
    logic [COEF_W-1:0]   r_res [NCOEF];

    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_dvd, div_dvs, div_q, acc_mag;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [STAT_W-1:0]    r_m_tuser;

    logic signed [MAG_W-1:0] diff_a, diff_b;
    logic [MAG_W-1:0]        mag_a, mag_b;
    logic [MAG_W+SCALE_W-1:0] prod_a, prod_b;
    logic signed [ACC_W-1:0] acc_sel;
    logic [M_TDATA_W-1:0]    res_flat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_a <= SCALE_W'(256);
            r_inv_b <= SCALE_W'(256);
            r_nu    <= NU_W'(4);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ALPHA_SCALE: r_inv_a <= i_cfg_data[SCALE_W-1:0];
                CFG_BETA_SCALE:  r_inv_b <= i_cfg_data[SCALE_W-1:0];
                CFG_NEIGHBORS:   r_nu    <= i_cfg_data[NU_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_row <= i_in_data[ROW_W-1:0];
            r_kind   <= t_kind'(i_in_kind);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load_wr) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Point memory: one write port, one registered read port.
    always_comb begin
        rd_en   = r_scan_on || i_cmd.hit_read || i_cmd.wdiv_start;
        rd_addr = r_scan_addr[AW-1:0];
        if (i_cmd.hit_read) begin
            rd_addr = r_hit_idx;
        end else if (i_cmd.wdiv_start) begin
            rd_addr = r_bi[i_cmd.nb[KIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mem[r_count[AW-1:0]] <= r_in_row;
        end
        if (rd_en) begin
            r_rd_row <= mem[rd_addr];
        end
    end

    // Scan address generator and distance pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && CW'(r_scan_addr + 1'b1) == r_count) begin
                r_scan_on <= 1'b0;
            end
            r_v1 <= r_scan_on;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
        end else if (r_scan_on) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
        r_i1 <= r_scan_addr[AW-1:0];
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
    end

    always_comb begin
        diff_a = $signed({r_in_row[ANG_W-1], r_in_row[ANG_W-1:0]})
               - $signed({r_rd_row[ANG_W-1], r_rd_row[ANG_W-1:0]});
        diff_b = $signed({r_in_row[2*ANG_W-1], r_in_row[2*ANG_W-1:ANG_W]})
               - $signed({r_rd_row[2*ANG_W-1], r_rd_row[2*ANG_W-1:ANG_W]});
        mag_a  = diff_a[MAG_W-1] ? MAG_W'(-diff_a) : MAG_W'(diff_a);
        mag_b  = diff_b[MAG_W-1] ? MAG_W'(-diff_b) : MAG_W'(diff_b);
        prod_a = mag_a * r_inv_a;
        prod_b = mag_b * r_inv_b;
    end

    always_ff @(posedge i_clk) begin
        r_da  <= prod_a[MAG_W+SCALE_W-1:8];
        r_db  <= prod_b[MAG_W+SCALE_W-1:8];
        r_da2 <= r_da * r_da;
        r_db2 <= r_db * r_db;
        r_d2  <= D2_W'(r_da2) + D2_W'(r_db2);
    end

    // Nearest list insertion.
    always_comb begin
        k_c = (r_nu == '0) ? NB_CNT_W'(1) : NB_CNT_W'(r_nu);
        if (k_c > NB_CNT_W'(MAX_NEIGHBORS)) begin
            k_c = NB_CNT_W'(MAX_NEIGHBORS);
        end
        if (16'(k_c) > 16'(r_count)) begin
            k_c = NB_CNT_W'(r_count);
        end
        pos = '0;
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (j < int'(r_nsel) && r_bd[j] <= r_d2) begin
                pos = pos + 1'b1;
            end
        end
        skip = (r_nsel == r_k) && (pos == r_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsel <= '0;
            r_k    <= NB_CNT_W'(1);
            r_hit  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_nsel <= '0;
            r_k    <= k_c;
            r_hit  <= 1'b0;
        end else if (r_v4 && !r_hit) begin
            if (r_d2 == '0) begin
                r_hit <= 1'b1;
            end else if (!skip && r_nsel != r_k) begin
                r_nsel <= r_nsel + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && !r_hit) begin
            if (r_d2 == '0) begin
                r_hit_idx <= r_i4;
            end else if (!skip) begin
                for (int j = 0; j < MAX_NEIGHBORS; j++) begin
                    if (j == int'(pos)) begin
                        r_bd[j] <= r_d2;
                        r_bi[j] <= r_i4;
                    end else if (j > int'(pos)) begin
                        r_bd[j] <= r_bd[(j > 0) ? j - 1 : 0];
                        r_bi[j] <= r_bi[(j > 0) ? j - 1 : 0];
                    end
                end
            end
        end
    end

    // Weights and weighted sums.
    always_comb begin
        sh_c = '0;
        for (int t = 0; t < D2_W - NUM_LIMIT_BIT; t++) begin
            if (r_bd[0][NUM_LIMIT_BIT+t]) begin
                sh_c = SHIFT_W'(t + 1);
            end
        end
        acc_sel = r_acc[i_cmd.co];
        acc_mag = acc_sel[ACC_W-1] ? DIV_W'(-acc_sel) : DIV_W'(acc_sel);
        div_start = i_cmd.wdiv_start || i_cmd.bdiv_start;
        if (i_cmd.wdiv_start) begin
            div_dvd = r_num;
            div_dvs = DIV_W'(r_bd[i_cmd.nb[KIW-1:0]]) >> r_shift;
        end else begin
            div_dvd = acc_mag + (r_wsum >> 1);
            div_dvs = r_wsum;
        end
    end

    knn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_shift <= sh_c;
            r_num   <= (DIV_W'(r_bd[0]) >> sh_c) << 16;
            r_wsum  <= '0;
            for (int m = 0; m < NCOEF; m++) begin
                r_acc[m] <= '0;
            end
        end else begin
            if (i_cmd.w_latch) begin
                r_w    <= div_q[W_W-1:0];
                r_wsum <= r_wsum + div_q;
            end
            if (r_pvld) begin
                r_acc[r_pidx] <= r_acc[r_pidx] + ACC_W'(r_prod);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= $signed(r_rd_row[2*ANG_W + COEF_W*i_cmd.co +: COEF_W])
                    * $signed({1'b0, r_w});
            r_pidx <= i_cmd.co;
        end
        if (i_cmd.b_store) begin
            if (!acc_sel[ACC_W-1]) begin
                r_res[i_cmd.co] <= (div_q > DIV_W'(32'h7FFF_FFFF)) ?
                                   32'h7FFF_FFFF : div_q[COEF_W-1:0];
            end else begin
                r_res[i_cmd.co] <= (div_q > DIV_W'(33'h1_0000_0000 >> 1)) ?
                                   32'h8000_0000 : COEF_W'(-div_q[COEF_W-1:0]);
            end
        end
    end

    // Result register.
    always_comb begin
        for (int m = 0; m < NCOEF; m++) begin
            res_flat[m*COEF_W +: COEF_W] = r_res[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_tuser <= i_cmd.status;
            case (i_cmd.src)
                SRC_ROW: r_m_tdata <= r_rd_row[ROW_W-1:2*ANG_W];
                SRC_RES: r_m_tdata <= res_flat;
                default: r_m_tdata <= '0;
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.empty     = (r_count == '0);
        o_sts.full      = (r_count == CW'(TABLE_DEPTH));
        o_sts.scan_busy = r_scan_on || r_v1 || r_v2 || r_v3 || r_v4;
        o_sts.hit       = r_hit;
        o_sts.nsel      = r_nsel;
        o_sts.div_done  = div_done;
        o_sts.out_free  = !r_m_tvalid || i_m_tready;
    end

    `KNN_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `KNN_ASSERT_IMP(a_nsel_k, i_clk, i_rst_n, 1'b1, r_nsel <= r_k)
    `KNN_ASSERT_IMP(a_div_free, i_clk, i_rst_n, div_start, !div_busy)
    `KNN_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_m_tvalid)
endmodule

FILE: design/knn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer for load, clear and query requests.
// ----------------------------------------------------------------------------
module knn_ctrl
    import knn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state              r_state, n_state;
    logic [NB_IDX_W-1:0] r_j, n_j;
    logic [CO_IDX_W-1:0] r_c, n_c;
    t_status             r_status, n_status;
    t_src                r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_j      <= '0;
            r_c      <= '0;
            r_status <= STS_EMPTY;
            r_src    <= SRC_ZERO;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_c      <= n_c;
            r_status <= n_status;
            r_src    <= n_src;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_c        = r_c;
        n_status   = r_status;
        n_src      = r_src;
        o_cmd      = '0;
        o_cmd.nb   = r_j;
        o_cmd.co   = r_c;
        o_cmd.status = r_status;
        o_cmd.src  = r_src;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_src = SRC_ZERO;
                case (i_sts.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_status = STS_CLEARED;
                        n_state  = ST_EMIT;
                    end
                    KIND_LOAD: begin
                        if (i_sts.full) begin
                            n_status = STS_FULL;
                        end else begin
                            o_cmd.load_wr = 1'b1;
                            n_status = STS_LOADED;
                        end
                        n_state = ST_EMIT;
                    end
                    default: begin
                        if (i_sts.empty) begin
                            n_status = STS_EMPTY;
                            n_state  = ST_EMIT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (!i_sts.scan_busy) begin
                    if (i_sts.hit) begin
                        o_cmd.hit_read = 1'b1;
                        n_state = ST_HIT_RD;
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_HIT_RD: begin
                n_status = STS_EXACT;
                n_src    = SRC_ROW;
                n_state  = ST_EMIT;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_j = '0;
                n_state = ST_W_START;
            end
            ST_W_START: begin
                o_cmd.wdiv_start = 1'b1;
                n_state = ST_W_WAIT;
            end
            ST_W_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_W_LATCH;
                end
            end
            ST_W_LATCH: begin
                o_cmd.w_latch = 1'b1;
                n_c = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_c = r_c + 1'b1;
                if (r_c == CO_IDX_W'(NCOEF - 1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_j = r_j + 1'b1;
                n_c = '0;
                if (NB_CNT_W'(r_j) + 1'b1 == i_sts.nsel) begin
                    n_state = ST_B_START;
                end else begin
                    n_state = ST_W_START;
                end
            end
            ST_B_START: begin
                o_cmd.bdiv_start = 1'b1;
                n_state = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_B_STORE;
                end
            end
            ST_B_STORE: begin
                o_cmd.b_store = 1'b1;
                if (r_c == CO_IDX_W'(NCOEF - 1)) begin
                    n_status = STS_BLEND;
                    n_src    = SRC_RES;
                    n_state  = ST_EMIT;
                end else begin
                    n_c = r_c + 1'b1;
                    n_state = ST_B_START;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
